[hw/rtl/bua_pkg.sv]
// Shared constants, codes and types of the bitmap unit allocator.
// No dependencies; used by bua_store and bitmap_unit_allocator.
package bua_pkg;

    localparam int NUM_UNITS  = 1024;
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_LOG2  = $clog2(UNIT_BYTES);
    localparam int IDX_W      = $clog2(NUM_UNITS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int REQ_W      = 15;
    localparam int UREQ_W     = REQ_W - UNIT_LOG2 + 1;
    localparam int ADDR_W     = 32;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
    localparam logic [2:0] ST_OUTSIDE   = 3'd3;
    localparam logic [2:0] ST_MISALIGN  = 3'd4;
    localparam logic [2:0] ST_NOT_START = 3'd5;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;

    localparam logic REG_BASE   = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    typedef struct packed {
        logic              used_we;
        logic              used_wdata;
        logic              len_we;
        logic [IDX_W-1:0]  len_waddr;
        logic [CNT_W-1:0]  len_wdata;
    } t_wr_ctl;

endpackage

[hw/rtl/bua_store.sv]
// Used-bit map and block-length table, one read address for both; reads are registered.
// Depends on bua_pkg.
module bua_store (
    input  logic                  i_clk,
    input  logic [bua_pkg::IDX_W-1:0] i_raddr,
    input  logic [bua_pkg::IDX_W-1:0] i_used_waddr,
    input  bua_pkg::t_wr_ctl      i_wr,
    output logic                  o_rd_used,
    output logic [bua_pkg::CNT_W-1:0] o_rd_len
);
    import bua_pkg::*;

    logic             used_mem [0:NUM_UNITS-1];
    logic [CNT_W-1:0] len_mem  [0:NUM_UNITS-1];

    always_ff @(posedge i_clk) begin
        o_rd_used <= used_mem[i_raddr];
        if (i_wr.used_we) begin
            used_mem[i_used_waddr] <= i_wr.used_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_len <= len_mem[i_raddr];
        if (i_wr.len_we) begin
            len_mem[i_wr.len_waddr] <= i_wr.len_wdata;
        end
    end

endmodule

[hw/rtl/bitmap_unit_allocator.sv]
// Top level of the bitmap unit allocator: sequencer around one cursor and unit store.
// Depends on bua_pkg and bua_store.
//
// channel   direction  handshake                 payload
// command   in         start high, busy low      i_action, i_request_bytes, i_align_log2,
//                                                i_block_addr
// result    out        o_done one-cycle strobe   o_status, o_result_addr, o_moved,
//                                                o_avail_units
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// A cursor walks the store one unit per cycle. Allocate scans for a free run, then marks
// each unit claimed; free locates the block and clears its units; a moving resize can
// add a grow check, a scan and the clearing of the old block's units.
// After reset a clearing pass over all NUM_UNITS units runs with busy high; config is taken.
// Writing active_units from idle recounts free units below min(active_units, NUM_UNITS),
// config not ready meanwhile; during the clearing pass it sets the free count directly.
// The receiver cannot stall: o_done is high for a single cycle only.
module bitmap_unit_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_action,
    input  logic [bua_pkg::REQ_W-1:0] i_request_bytes,
    input  logic [3:0]                i_align_log2,
    input  logic [bua_pkg::ADDR_W-1:0] i_block_addr,
    output logic                      o_done,
    output logic [2:0]                o_status,
    output logic [bua_pkg::ADDR_W-1:0] o_result_addr,
    output logic                      o_moved,
    output logic [bua_pkg::CNT_W-1:0] o_avail_units,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [bua_pkg::ADDR_W-1:0] i_cfg_data
);
    import bua_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RECOUNT, S_LOCATE, S_ALLOC_INIT, S_ALLOC_SCAN, S_GROW_CHK, S_MARK
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [CNT_W-1:0]   r_active, n_active;
    logic [CNT_W-1:0]   r_free, n_free;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_s, n_s;
    logic [CNT_W:0]     r_end, n_end;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [1:0]         r_action, n_action;
    logic               r_bytes_zero, n_bytes_zero;
    logic [UREQ_W-1:0]  r_units, n_units;
    logic [3:0]         r_alog, n_alog;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [ADDR_W-1:0]  r_caddr, n_caddr;
    logic [ADDR_W-1:0]  r_saddr, n_saddr;
    logic [IDX_W-1:0]   r_old_s, n_old_s;
    logic [CNT_W-1:0]   r_old_u, n_old_u;
    logic               r_mval, n_mval;
    logic               r_mv, n_mv;
    logic               r_pend, n_pend;
    logic               r_done, n_done;
    logic [2:0]         r_status, n_status;
    logic [ADDR_W-1:0]  r_res, n_res;
    logic               r_moved, n_moved;

    t_wr_ctl            wr;
    logic               rd_used;
    logic [CNT_W-1:0]   rd_len;
    logic [CNT_W-1:0]   lim;
    logic [ADDR_W-1:0]  off;
    logic [UREQ_W:0]    req_sum;
    logic [15:0]        amask;
    logic [UREQ_W+1:0]  run_end;
    logic [UREQ_W+1:0]  run_len;
    logic [ADDR_W-1:0]  found_addr;

    bua_store u_store (
        .i_clk       (i_clk),
        .i_raddr     (n_idx[IDX_W-1:0]),
        .i_used_waddr(r_idx[IDX_W-1:0]),
        .i_wr        (wr),
        .o_rd_used   (rd_used),
        .o_rd_len    (rd_len)
    );

    assign lim     = (r_active > CNT_W'(NUM_UNITS)) ? CNT_W'(NUM_UNITS) : r_active;
    assign off     = i_block_addr - r_base;
    assign req_sum = (UREQ_W+1)'(({1'b0, i_request_bytes} + 16'(UNIT_BYTES - 1)) >> UNIT_LOG2);
    assign amask   = 16'((17'(1) << r_alog) - 17'(1));
    assign run_end = (UREQ_W+2)'(r_s) + (UREQ_W+2)'(r_units);
    assign run_len = (UREQ_W+2)'(r_idx) + (UREQ_W+2)'(1) - (UREQ_W+2)'(r_s);
    assign found_addr = (r_idx == r_s) ? r_caddr : r_saddr;

    assign busy          = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE && !start) || (r_state == S_CLEAR);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_result_addr = r_res;
    assign o_moved       = r_moved;
    assign o_avail_units = r_free;

    always_comb begin
        n_state = r_state;  n_base = r_base;  n_active = r_active;  n_free = r_free;
        n_idx = r_idx;  n_s = r_s;  n_end = r_end;  n_cnt = r_cnt;  n_action = r_action;
        n_bytes_zero = r_bytes_zero;  n_units = r_units;  n_alog = r_alog;  n_addr = r_addr;
        n_caddr = r_caddr;  n_saddr = r_saddr;  n_old_s = r_old_s;  n_old_u = r_old_u;
        n_mval = r_mval;  n_mv = r_mv;  n_pend = r_pend;  n_done = 1'b0;
        n_status = r_status;  n_res = r_res;  n_moved = r_moved;
        wr = '0;

        if (i_cfg_valid && o_cfg_ready && !(r_state == S_IDLE && start)) begin
            if (i_cfg_index == REG_BASE) begin
                n_base = i_cfg_data & ~ADDR_W'(UNIT_BYTES - 1);
            end else begin
                n_active = i_cfg_data[CNT_W-1:0];
                if (r_state == S_CLEAR) begin
                    n_free = (i_cfg_data[CNT_W-1:0] > CNT_W'(NUM_UNITS)) ?
                             CNT_W'(NUM_UNITS) : i_cfg_data[CNT_W-1:0];
                end else begin
                    n_state = S_RECOUNT;
                    n_idx   = '0;
                    n_cnt   = '0;
                end
            end
        end

        case (r_state)
            S_CLEAR: begin
                wr.used_we    = 1'b1;
                wr.len_we     = 1'b1;
                wr.len_waddr  = r_idx[IDX_W-1:0];
                n_idx = r_idx + 1'b1;
                if (r_idx == CNT_W'(NUM_UNITS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_action     = i_action;
                    n_bytes_zero = (i_request_bytes == '0);
                    n_units      = req_sum[UREQ_W-1:0];
                    n_alog       = i_align_log2;
                    n_addr       = i_block_addr;
                    n_mv         = 1'b0;
                    n_pend       = 1'b0;
                    n_status     = ST_OK;
                    n_res        = '0;
                    n_moved      = 1'b0;
                    n_idx        = CNT_W'(off[UNIT_LOG2 +: IDX_W]);
                    case (i_action)
                        ACT_ALLOC: n_state = S_ALLOC_INIT;
                        ACT_FREE, ACT_RESIZE: begin
                            if (i_block_addr == '0) begin
                                if (i_action == ACT_RESIZE) begin
                                    n_state = S_ALLOC_INIT;
                                end else begin
                                    n_done = 1'b1;
                                end
                            end else if (off >= (ADDR_W'(lim) << UNIT_LOG2)) begin
                                n_status = ST_OUTSIDE;
                                n_done   = 1'b1;
                            end else if (off[UNIT_LOG2-1:0] != '0) begin
                                n_status = ST_MISALIGN;
                                n_done   = 1'b1;
                            end else begin
                                n_state = S_LOCATE;
                            end
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_RECOUNT: begin
                if (r_idx >= lim) begin
                    n_free  = r_cnt;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(!rd_used);
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LOCATE: begin
                n_old_s = r_idx[IDX_W-1:0];
                n_old_u = rd_len;
                wr.len_waddr = r_idx[IDX_W-1:0];
                if (rd_len == '0) begin
                    n_status = ST_NOT_START;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_action == ACT_FREE || r_bytes_zero) begin
                    wr.len_we = 1'b1;
                    n_end   = (CNT_W+1)'(r_idx) + (CNT_W+1)'(rd_len);
                    n_mval  = 1'b0;
                    n_state = S_MARK;
                end else if ((CNT_W+1)'(r_units) <= (CNT_W+1)'(rd_len)) begin
                    wr.len_we     = 1'b1;
                    wr.len_wdata  = r_units[CNT_W-1:0];
                    n_res = r_addr;
                    if ((CNT_W+1)'(r_units) < (CNT_W+1)'(rd_len)) begin
                        n_idx   = CNT_W'((CNT_W+1)'(r_idx) + (CNT_W+1)'(r_units));
                        n_end   = (CNT_W+1)'(r_idx) + (CNT_W+1)'(rd_len);
                        n_mval  = 1'b0;
                        n_state = S_MARK;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if ((UREQ_W+2)'(r_idx) + (UREQ_W+2)'(r_units) <= (UREQ_W+2)'(lim)) begin
                    n_idx   = r_idx + rd_len;
                    n_state = S_GROW_CHK;
                end else begin
                    n_mv    = 1'b1;
                    n_state = S_ALLOC_INIT;
                end
            end
            S_GROW_CHK: begin
                if (rd_used) begin
                    n_mv    = 1'b1;
                    n_state = S_ALLOC_INIT;
                end else if ((UREQ_W+2)'(r_idx) + (UREQ_W+2)'(1) ==
                             (UREQ_W+2)'(r_old_s) + (UREQ_W+2)'(r_units)) begin
                    wr.len_we     = 1'b1;
                    wr.len_waddr  = r_old_s;
                    wr.len_wdata  = r_units[CNT_W-1:0];
                    n_res   = r_addr;
                    n_idx   = CNT_W'(r_old_s) + r_old_u;
                    n_end   = (CNT_W+1)'(r_old_s) + (CNT_W+1)'(r_units);
                    n_mval  = 1'b1;
                    n_state = S_MARK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_ALLOC_INIT: begin
                n_res = '0;
                if (r_bytes_zero) begin
                    n_status = ST_ZERO_SIZE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if ((UREQ_W+1)'(r_units) > (UREQ_W+1)'(lim) ||
                             (UREQ_W+1)'(r_free) < (UREQ_W+1)'(r_units)) begin
                    n_status = ST_NO_SPACE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = '0;
                    n_s     = '0;
                    n_caddr = r_base;
                    n_state = S_ALLOC_SCAN;
                end
            end
            S_ALLOC_SCAN: begin
                if (r_idx == r_s && run_end > (UREQ_W+2)'(lim)) begin
                    n_status = ST_NO_SPACE;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_idx == r_s && (r_caddr[15:0] & amask) != '0) begin
                    n_idx   = r_idx + 1'b1;
                    n_s     = r_idx + 1'b1;
                    n_caddr = r_caddr + ADDR_W'(UNIT_BYTES);
                end else begin
                    n_saddr = found_addr;
                    if (rd_used) begin
                        n_idx   = r_idx + 1'b1;
                        n_s     = r_idx + 1'b1;
                        n_caddr = r_caddr + ADDR_W'(UNIT_BYTES);
                    end else if (run_len == (UREQ_W+2)'(r_units)) begin
                        wr.len_we     = 1'b1;
                        wr.len_waddr  = r_s[IDX_W-1:0];
                        wr.len_wdata  = r_units[CNT_W-1:0];
                        n_res   = found_addr;
                        n_idx   = r_s;
                        n_end   = (CNT_W+1)'(run_end);
                        n_mval  = 1'b1;
                        n_pend  = r_mv;
                        n_state = S_MARK;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_caddr = r_caddr + ADDR_W'(UNIT_BYTES);
                    end
                end
            end
            S_MARK: begin
                wr.used_we    = 1'b1;
                wr.used_wdata = r_mval;
                if (r_idx < lim) begin
                    n_free = r_mval ? r_free - 1'b1 : r_free + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if ((CNT_W+1)'(r_idx) + (CNT_W+1)'(1) >= r_end) begin
                    if (r_pend) begin
                        wr.len_we     = 1'b1;
                        wr.len_waddr  = r_old_s;
                        n_idx   = CNT_W'(r_old_s);
                        n_end   = (CNT_W+1)'(r_old_s) + (CNT_W+1)'(r_old_u);
                        n_mval  = 1'b0;
                        n_pend  = 1'b0;
                        n_moved = 1'b1;
                    end else begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_base   <= '0;
            r_active <= CNT_W'(NUM_UNITS);
            r_free   <= CNT_W'(NUM_UNITS);
            r_idx    <= '0;
            r_done   <= 1'b0;
            r_pend   <= 1'b0;
            r_mv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_active <= n_active;
            r_free   <= n_free;
            r_idx    <= n_idx;
            r_done   <= n_done;
            r_pend   <= n_pend;
            r_mv     <= n_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s          <= n_s;
        r_end        <= n_end;
        r_cnt        <= n_cnt;
        r_action     <= n_action;
        r_bytes_zero <= n_bytes_zero;
        r_units      <= n_units;
        r_alog       <= n_alog;
        r_addr       <= n_addr;
        r_caddr      <= n_caddr;
        r_saddr      <= n_saddr;
        r_old_s      <= n_old_s;
        r_old_u      <= n_old_u;
        r_mval       <= n_mval;
        r_status     <= n_status;
        r_res        <= n_res;
        r_moved      <= n_moved;
    end

endmodule

[dv/tb.sv]
// Self-checking testbench for bitmap_unit_allocator: a directed table, then random phases
// under changing register settings, checked against an in-bench allocator predictor.
// Depends on bua_pkg and the allocator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bua_pkg::*;

    typedef struct {
        logic [2:0]        status;
        logic [ADDR_W-1:0] addr;
        logic              moved;
        logic [CNT_W-1:0]  avail_units;
    } t_alloc_result;

    typedef struct {
        bit                is_cfg;
        logic [1:0]        action;
        logic [REQ_W-1:0]  bytes;
        logic [3:0]        align;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        t_alloc_result     want;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_action = '0;
    logic [REQ_W-1:0]    i_request_bytes = '0;
    logic [3:0]          i_align_log2 = '0;
    logic [ADDR_W-1:0]   i_block_addr = '0;
    logic                o_done;
    logic [2:0]          o_status;
    logic [ADDR_W-1:0]   o_result_addr;
    logic                o_moved;
    logic [CNT_W-1:0]    o_avail_units;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = REG_BASE;
    logic [ADDR_W-1:0]   i_cfg_data = '0;

    bitmap_unit_allocator uut (.*);

    always #10 i_clk = ~i_clk;

    // allocator image
    bit              used_map [NUM_UNITS];
    int unsigned     blk_len [NUM_UNITS];
    int unsigned     free_cnt;
    logic [ADDR_W-1:0] heap_base;
    int unsigned     active_reg;

    t_alloc_result   pending_results [$];
    t_alloc_result   typed_results [$];
    bit              typed_flags [$];
    t_row            rows [$];
    int              n_errors;
    int              n_results;
    int              n_items;
    bit              no_idle;

    function automatic int unsigned heap_limit();
        return (active_reg > NUM_UNITS) ? NUM_UNITS : active_reg;
    endfunction

    function automatic logic [ADDR_W-1:0] unit_address(int unsigned u);
        return heap_base + ADDR_W'(u * UNIT_BYTES);
    endfunction

    function automatic void recount_free();
        free_cnt = 0;
        for (int unsigned i = 0; i < heap_limit(); i++)
            if (!used_map[i]) free_cnt++;
    endfunction

    function automatic void claim_units(int unsigned first, int unsigned n);
        int unsigned lim;
        lim = heap_limit();
        for (int unsigned i = first; i < first + n && i < NUM_UNITS; i++)
            if (!used_map[i]) begin
                used_map[i] = 1'b1;
                if (i < lim && free_cnt > 0) free_cnt--;
            end
    endfunction

    function automatic void release_units(int unsigned first, int unsigned n);
        int unsigned lim;
        lim = heap_limit();
        for (int unsigned i = first; i < first + n && i < NUM_UNITS; i++)
            if (used_map[i]) begin
                used_map[i] = 1'b0;
                if (i < lim) free_cnt++;
            end
    endfunction

    function automatic logic [2:0] first_fit(int unsigned bytes, int unsigned alog,
                                             output logic [ADDR_W-1:0] addr);
        int unsigned lim, units, s;
        logic [ADDR_W:0] align;
        logic [ADDR_W-1:0] a;
        bit ok;
        addr = '0;
        lim = heap_limit();
        if (bytes == 0) return ST_ZERO_SIZE;
        units = (bytes + UNIT_BYTES - 1) / UNIT_BYTES;
        if (units > lim || free_cnt < units) return ST_NO_SPACE;
        align = 33'd1 << alog;
        if (align < UNIT_BYTES) align = UNIT_BYTES;
        for (s = 0; s + units <= lim; s++) begin
            a = unit_address(s);
            if ((a & (align[ADDR_W-1:0] - 1)) != 0) continue;
            ok = 1'b1;
            for (int unsigned k = 0; k < units; k++)
                if (used_map[s + k]) begin
                    ok = 1'b0;
                    s += k;
                    break;
                end
            if (!ok) continue;
            claim_units(s, units);
            blk_len[s] = units;
            addr = a;
            return ST_OK;
        end
        return ST_NO_SPACE;
    endfunction

    function automatic logic [2:0] find_block(logic [ADDR_W-1:0] addr,
                                              output int unsigned first);
        logic [ADDR_W-1:0] off;
        off = addr - heap_base;
        first = 0;
        if (off >= heap_limit() * UNIT_BYTES) return ST_OUTSIDE;
        if (off % UNIT_BYTES != 0) return ST_MISALIGN;
        if (blk_len[off / UNIT_BYTES] == 0) return ST_NOT_START;
        first = off / UNIT_BYTES;
        return ST_OK;
    endfunction

    function automatic logic [2:0] free_block(logic [ADDR_W-1:0] addr);
        int unsigned s;
        logic [2:0] st;
        if (addr == 0) return ST_OK;
        st = find_block(addr, s);
        if (st != ST_OK) return st;
        release_units(s, blk_len[s]);
        blk_len[s] = 0;
        return ST_OK;
    endfunction

    function automatic t_alloc_result predict_alloc(logic [1:0] act, int unsigned bytes,
                                                    int unsigned alog, logic [ADDR_W-1:0] addr);
        t_alloc_result r;
        int unsigned s, old_u, new_u;
        bit grow;
        r = '{ST_OK, '0, 1'b0, '0};
        if (act == ACT_ALLOC) begin
            r.status = first_fit(bytes, alog, r.addr);
        end else if (act == ACT_FREE) begin
            r.status = free_block(addr);
        end else if (act == ACT_RESIZE) begin
            if (addr == 0) r.status = first_fit(bytes, alog, r.addr);
            else if (bytes == 0) r.status = free_block(addr);
            else begin
                r.status = find_block(addr, s);
                if (r.status == ST_OK) begin
                    old_u = blk_len[s];
                    new_u = (bytes + UNIT_BYTES - 1) / UNIT_BYTES;
                    if (new_u <= old_u) begin
                        release_units(s + new_u, old_u - new_u);
                        blk_len[s] = new_u;
                        r.addr = addr;
                    end else begin
                        grow = (s + new_u <= heap_limit());
                        for (int unsigned k = s + old_u; grow && k < s + new_u; k++)
                            if (used_map[k]) grow = 1'b0;
                        if (grow) begin
                            claim_units(s + old_u, new_u - old_u);
                            blk_len[s] = new_u;
                            r.addr = addr;
                        end else begin
                            r.status = first_fit(bytes, alog, r.addr);
                            if (r.status == ST_OK) begin
                                release_units(s, old_u);
                                blk_len[s] = 0;
                                r.moved = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        r.avail_units = CNT_W'(free_cnt);
        return r;
    endfunction

    function automatic bit same_result(t_alloc_result a, t_alloc_result b);
        return a.status === b.status && a.addr === b.addr && a.moved === b.moved &&
               a.avail_units === b.avail_units;
    endfunction

    task automatic report(string what);
        n_errors++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_alloc_result w, t;
        bit tf;
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report("result with nothing pending");
            end else begin
                w = pending_results.pop_front();
                t = typed_results.pop_front();
                tf = typed_flags.pop_front();
                if (tf && !same_result(t, w)) report("typed row disagrees with predictor");
                if (o_status !== w.status)
                    report($sformatf("status %0d want %0d", o_status, w.status));
                if (o_result_addr !== w.addr)
                    report($sformatf("addr %h want %h", o_result_addr, w.addr));
                if (o_moved !== w.moved)
                    report($sformatf("moved %b want %b", o_moved, w.moved));
                if (o_avail_units !== w.avail_units)
                    report($sformatf("free %0d want %0d", o_avail_units, w.avail_units));
            end
        end
    end

    task automatic issue(logic [1:0] act, logic [REQ_W-1:0] bytes, logic [3:0] alog,
                         logic [ADDR_W-1:0] addr, bit typed, t_alloc_result want);
        if (!no_idle && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_request_bytes <= bytes;
        i_align_log2 <= alog;
        i_block_addr <= addr;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_alloc(act, bytes, alog, addr));
        typed_results.push_back(want);
        typed_flags.push_back(typed);
        n_items++;
    endtask

    task automatic write_reg(logic idx, logic [ADDR_W-1:0] data);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat ($urandom_range(1, 4)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_BASE) heap_base = data & ~ADDR_W'(UNIT_BYTES - 1);
        else begin
            active_reg = data & 32'h7FF;
            recount_free();
        end
    endtask

    function automatic logic [ADDR_W-1:0] pick_block();
        int unsigned u;
        u = $urandom_range(0, NUM_UNITS - 1);
        for (int unsigned i = 0; i < NUM_UNITS; i++) begin
            if (blk_len[(u + i) % NUM_UNITS] != 0 && (u + i) % NUM_UNITS < heap_limit())
                return unit_address((u + i) % NUM_UNITS);
        end
        return $urandom();
    endfunction

    function automatic int unsigned pick_bytes();
        if ($urandom_range(0, 19) == 0) return $urandom_range(1, 16384);
        return $urandom_range(1, 256);
    endfunction

    task automatic add_row(logic [1:0] act, int bytes, int alog, logic [ADDR_W-1:0] addr,
                           bit typed = 0, logic [2:0] st = ST_OK,
                           logic [ADDR_W-1:0] ra = '0, int fu = 0);
        t_row r;
        r.is_cfg = 1'b0;
        r.action = act;
        r.bytes = REQ_W'(bytes);
        r.align = 4'(alog);
        r.addr = addr;
        r.typed = typed;
        r.want = '{st, ra, 1'b0, CNT_W'(fu)};
        rows.push_back(r);
    endtask

    task automatic add_cfg(logic idx, logic [ADDR_W-1:0] data);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.addr = data;
        r.align = 4'(idx);
        rows.push_back(r);
    endtask

    task automatic random_phase(int n);
        int unsigned pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                issue(ACT_ALLOC, REQ_W'(pick_bytes()), 4'($urandom_range(0, 9)), '0, 0,
                      '{default: '0});
            else if (pick < 60)
                issue(ACT_FREE, REQ_W'($urandom()), 4'($urandom()), pick_block(), 0,
                      '{default: '0});
            else if (pick < 80)
                issue(ACT_RESIZE, REQ_W'(pick_bytes()), 4'($urandom_range(0, 9)),
                      pick_block(), 0, '{default: '0});
            else if (pick < 85)
                issue(ACT_RESIZE, REQ_W'($urandom_range(0, 1) ? 0 : pick_bytes()),
                      4'($urandom()), $urandom_range(0, 1) ? '0 : pick_block(), 0,
                      '{default: '0});
            else
                issue(2'($urandom()), REQ_W'($urandom_range(0, 32767)), 4'($urandom()),
                      $urandom(), 0, '{default: '0});
        end
    endtask

    initial begin
        #200_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        heap_base = '0;
        active_reg = NUM_UNITS;
        recount_free();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(ACT_ALLOC, 0, 0, '0, 1, ST_ZERO_SIZE, '0, 1024);
        add_row(ACT_ALLOC, 16384, 0, '0, 1, ST_OK, '0, 0);
        add_row(ACT_FREE, 0, 0, '0, 1, ST_OK, '0, 0);
        add_row(ACT_ALLOC, 16, 0, '0, 1, ST_NO_SPACE, '0, 0);
        add_row(ACT_RESIZE, 0, 0, '0, 1, ST_ZERO_SIZE, '0, 0);
        add_cfg(REG_BASE, 32'h1F);
        add_row(ACT_FREE, 0, 0, 32'h10, 1, ST_OK, '0, 1024);
        add_row(ACT_FREE, 0, 0, 32'h4010, 1, ST_OUTSIDE, '0, 1024);
        add_row(ACT_FREE, 0, 0, 32'h18, 1, ST_MISALIGN, '0, 1024);
        add_row(ACT_FREE, 0, 0, 32'h20, 1, ST_NOT_START, '0, 1024);
        add_row(2'd3, 32767, 15, 32'hFFFF_FFFF, 1, ST_OK, '0, 1024);
        add_row(ACT_ALLOC, 100, 3, '0, 1, ST_OK, 32'h10, 1017);
        add_row(ACT_ALLOC, 16, 14, '0, 1, ST_OK, 32'h4000, 1016);
        add_row(ACT_RESIZE, 50, 0, 32'h10);
        add_row(ACT_RESIZE, 200, 0, 32'h10);
        add_row(ACT_ALLOC, 32, 15, '0);
        add_row(ACT_RESIZE, 2000, 4, 32'h10);
        add_row(ACT_RESIZE, 64, 0, 32'h30);
        add_row(ACT_RESIZE, 0, 0, 32'h4000);
        add_row(ACT_ALLOC, 32767, 0, '0);
        add_cfg(REG_ACTIVE, 0);
        add_row(ACT_ALLOC, 16, 0, '0);
        add_cfg(REG_ACTIVE, 32'h7FF);
        add_cfg(REG_BASE, 32'hFFFF_FFF0);
        add_row(ACT_ALLOC, 64, 0, '0);
        add_row(ACT_FREE, 0, 0, 32'hFFFF_FFF0);

        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].align[0], rows[i].addr);
            else issue(rows[i].action, rows[i].bytes, rows[i].align, rows[i].addr,
                       rows[i].typed, rows[i].want);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(REG_BASE, 32'h0); write_reg(REG_ACTIVE, 1024); end
                1: begin write_reg(REG_BASE, $urandom()); write_reg(REG_ACTIVE, 64); end
                2: begin write_reg(REG_BASE, 32'hFFFF_FFF0); write_reg(REG_ACTIVE, 1); end
                3: begin write_reg(REG_BASE, $urandom()); write_reg(REG_ACTIVE, 2047); end
                4: write_reg(REG_ACTIVE, $urandom_range(0, 2047));
                default: begin write_reg(REG_BASE, 32'h1000); write_reg(REG_ACTIVE, 1024); end
            endcase
            no_idle = (ph == 4);
            random_phase(93);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d items and %0d results over directed cases and six register settings",
                 n_items, n_results);
        $display("%0d mismatches", n_errors);
        if (n_errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

[files.f]
hw/rtl/bua_pkg.sv
hw/rtl/bua_store.sv
hw/rtl/bitmap_unit_allocator.sv
dv/tb.sv
